@@ hw/rtl/ray_oriented_box_slab_test_core_assert.svh @@
// Assertion macros for the ray versus oriented box slab test core.
`ifndef RAY_ORIENTED_BOX_SLAB_TEST_CORE_ASSERT_SVH
`define RAY_ORIENTED_BOX_SLAB_TEST_CORE_ASSERT_SVH
// Same-cycle implication, checked on the rising clock edge outside reset.
`define ROBST_ASSERT_IMPLY(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |-> (post)) \
      else $error("slab test core: implication failed");
// Next-cycle implication, checked on the rising clock edge outside reset.
`define ROBST_ASSERT_NEXT(label, pre, post) \
   label: assert property (@(posedge clock) disable iff (reset) (pre) |=> (post)) \
      else $error("slab test core: next-cycle implication failed");
`endif

@@ hw/rtl/robst_pkg.sv @@
// Shared constants and register indexes of the slab test core.
package robst_pkg;
   localparam int unsigned CSR_INDEX_WIDTH = 3;
   localparam int unsigned PAR_LIMIT = 66;
   localparam int unsigned AXIS_WIDTH = 16;
   localparam int unsigned AXIS_FRAC = 14;
   localparam int unsigned EXTENT_WIDTH = 31;
   localparam logic signed [31:0] DIST_MAX = 32'sh7FFF_FFFF;
   localparam logic signed [31:0] DIST_MIN = 32'sh8000_0000;

   typedef enum logic [CSR_INDEX_WIDTH-1:0] {
      CSR_ORIGIN_X = 3'd0,
      CSR_ORIGIN_Y = 3'd1,
      CSR_ORIGIN_Z = 3'd2,
      CSR_DIR_X    = 3'd3,
      CSR_DIR_Y    = 3'd4,
      CSR_DIR_Z    = 3'd5
   } csr_index_type;
endpackage

@@ hw/rtl/robst_front.sv @@
// Front part: accepts a slab word and forms the cosine and the offset with one multiplier.
module robst_front import robst_pkg::*; #(
   parameter int unsigned COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [AXIS_WIDTH-1:0]  req_axis_x,
   input  logic signed [AXIS_WIDTH-1:0]  req_axis_y,
   input  logic signed [AXIS_WIDTH-1:0]  req_axis_z,
   input  logic [EXTENT_WIDTH-1:0]       req_half_extent,
   input  logic signed [COORD_WIDTH-1:0] req_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_y,
   input  logic signed [COORD_WIDTH-1:0] req_center_z,
   input  logic                          req_last_slab,
   input  logic signed [COORD_WIDTH-1:0] origin_x,
   input  logic signed [COORD_WIDTH-1:0] origin_y,
   input  logic signed [COORD_WIDTH-1:0] origin_z,
   input  logic signed [COORD_WIDTH-1:0] dir_x,
   input  logic signed [COORD_WIDTH-1:0] dir_y,
   input  logic signed [COORD_WIDTH-1:0] dir_z,
   output logic                          push_valid,
   input  logic                          push_ready,
   output logic signed [COORD_WIDTH+4:0] push_cos,
   output logic signed [COORD_WIDTH+4:0] push_dst,
   output logic [EXTENT_WIDTH-1:0]       push_half_extent,
   output logic                          push_parallel,
   output logic                          push_last
);
   localparam int unsigned PW = COORD_WIDTH + AXIS_WIDTH;
   localparam int unsigned AW = COORD_WIDTH + 4;
   localparam int unsigned DW = COORD_WIDTH + 5;

   typedef enum logic [1:0] {F_IDLE, F_MUL, F_PUSH} front_state_type;

   front_state_type             state_ff;
   logic [3:0]                  cnt_ff;
   logic signed [AXIS_WIDTH-1:0] ax_ff, ay_ff, az_ff;
   logic [EXTENT_WIDTH-1:0]     h_ff;
   logic signed [COORD_WIDTH-1:0] cx_ff, cy_ff, cz_ff;
   logic                        last_ff;
   logic signed [PW-1:0]        prod_ff;
   logic [1:0]                  grp_ff;
   logic                        prod_vld_ff;
   logic signed [AW-1:0]        acc_dir_ff, acc_org_ff, acc_cen_ff;
   logic signed [COORD_WIDTH-1:0] coord_sel;
   logic signed [AXIS_WIDTH-1:0] axis_sel;
   logic [1:0]                  grp_sel;
   logic signed [AW-1:0]        term_in;
   logic [DW-1:0]               abs_cos;

   always_comb begin
      unique case (cnt_ff)
         4'd0: begin coord_sel = dir_x;  axis_sel = ax_ff; grp_sel = 2'd0; end
         4'd1: begin coord_sel = dir_y;  axis_sel = ay_ff; grp_sel = 2'd0; end
         4'd2: begin coord_sel = dir_z;  axis_sel = az_ff; grp_sel = 2'd0; end
         4'd3: begin coord_sel = origin_x; axis_sel = ax_ff; grp_sel = 2'd1; end
         4'd4: begin coord_sel = origin_y; axis_sel = ay_ff; grp_sel = 2'd1; end
         4'd5: begin coord_sel = origin_z; axis_sel = az_ff; grp_sel = 2'd1; end
         4'd6: begin coord_sel = cx_ff;  axis_sel = ax_ff; grp_sel = 2'd2; end
         4'd7: begin coord_sel = cy_ff;  axis_sel = ay_ff; grp_sel = 2'd2; end
         default: begin coord_sel = cz_ff; axis_sel = az_ff; grp_sel = 2'd2; end
      endcase
   end

   // Dropping the low fraction bits of a two's complement product floors it.
   assign term_in = AW'($signed(prod_ff[PW-1:AXIS_FRAC]));

   assign req_ready  = (state_ff == F_IDLE);
   assign push_valid = (state_ff == F_PUSH);
   assign push_cos   = -DW'(acc_dir_ff);
   assign push_dst   = DW'(acc_org_ff) - DW'(acc_cen_ff);
   assign push_half_extent = h_ff;
   assign push_last  = last_ff;
   assign abs_cos    = push_cos[DW-1] ? DW'(-push_cos) : DW'(push_cos);
   assign push_parallel = (abs_cos < DW'(PAR_LIMIT));

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= F_IDLE;
         cnt_ff      <= '0;
         prod_vld_ff <= 1'b0;
      end else begin
         unique case (state_ff)
            F_IDLE: begin
               if (req_valid) begin
                  ax_ff <= req_axis_x;
                  ay_ff <= req_axis_y;
                  az_ff <= req_axis_z;
                  h_ff  <= req_half_extent;
                  cx_ff <= req_center_x;
                  cy_ff <= req_center_y;
                  cz_ff <= req_center_z;
                  last_ff <= req_last_slab;
                  acc_dir_ff <= '0;
                  acc_org_ff <= '0;
                  acc_cen_ff <= '0;
                  cnt_ff   <= '0;
                  state_ff <= F_MUL;
               end
            end
            F_MUL: begin
               prod_ff     <= coord_sel * axis_sel;
               grp_ff      <= grp_sel;
               prod_vld_ff <= (cnt_ff < 4'd9);
               if (prod_vld_ff) begin
                  unique case (grp_ff)
                     2'd0: acc_dir_ff <= acc_dir_ff + term_in;
                     2'd1: acc_org_ff <= acc_org_ff + term_in;
                     default: acc_cen_ff <= acc_cen_ff + term_in;
                  endcase
               end
               cnt_ff <= cnt_ff + 4'd1;
               if (cnt_ff == 4'd9) begin
                  state_ff    <= F_PUSH;
                  prod_vld_ff <= 1'b0;
               end
            end
            default: begin
               if (push_ready) begin
                  state_ff <= F_IDLE;
               end
            end
         endcase
      end
   end
endmodule

@@ hw/rtl/robst_fifo.sv @@
// Two-entry queue between the front and the back part.
module robst_fifo #(
   parameter int unsigned WIDTH = 8
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] push_data,
   output logic             full,
   input  logic             pop,
   output logic             not_empty,
   output logic [WIDTH-1:0] pop_data
);
   logic [WIDTH-1:0] mem_ff [2];
   logic             wr_ptr_ff, rd_ptr_ff;
   logic [1:0]       count_ff;

   assign full      = (count_ff == 2'd2);
   assign not_empty = (count_ff != 2'd0);
   assign pop_data  = mem_ff[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push && !full) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         if (push && !full) begin
            wr_ptr_ff <= !wr_ptr_ff;
         end
         if (pop && not_empty) begin
            rd_ptr_ff <= !rd_ptr_ff;
         end
         count_ff <= count_ff + 2'((push && !full) ? 1 : 0) - 2'((pop && not_empty) ? 1 : 0);
      end
   end
endmodule

@@ hw/rtl/robst_div.sv @@
// Serial restoring divider giving a saturated Q16.16 quotient.
module robst_div import robst_pkg::*; #(
   parameter int unsigned NUM_WIDTH = 38,
   parameter int unsigned DEN_WIDTH = 37
) (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        start,
   input  logic signed [NUM_WIDTH-1:0] num,
   input  logic signed [DEN_WIDTH-1:0] den,
   output logic                        done,
   output logic signed [31:0]          quot
);
   localparam int unsigned CW = NUM_WIDTH + DEN_WIDTH + 15;

   typedef enum logic [1:0] {D_IDLE, D_CHECK, D_RUN} div_state_type;

   div_state_type        state_ff;
   logic [NUM_WIDTH-1:0] un_ff;
   logic [DEN_WIDTH-1:0] ud_ff;
   logic                 neg_ff;
   logic [DEN_WIDTH:0]   rem_ff;
   logic [30:0]          sh_ff;
   logic [30:0]          q_ff;
   logic [4:0]           cnt_ff;
   logic                 done_ff;
   logic signed [31:0]   quot_ff;
   logic [DEN_WIDTH:0]   trial_in;
   logic                 ge_in;
   logic [30:0]          q_in;
   logic [NUM_WIDTH-1:0] un_hi_in;

   assign trial_in = {rem_ff[DEN_WIDTH-1:0], sh_ff[30]};
   assign ge_in    = (trial_in >= {1'b0, ud_ff});
   assign q_in     = {q_ff[29:0], ge_in};
   assign un_hi_in = un_ff >> 15;
   assign done     = done_ff;
   assign quot     = quot_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= D_IDLE;
         done_ff  <= 1'b0;
         cnt_ff   <= '0;
      end else begin
         done_ff <= 1'b0;
         unique case (state_ff)
            D_IDLE: begin
               if (start) begin
                  un_ff  <= num[NUM_WIDTH-1] ? NUM_WIDTH'(-num) : NUM_WIDTH'(num);
                  ud_ff  <= den[DEN_WIDTH-1] ? DEN_WIDTH'(-den) : DEN_WIDTH'(den);
                  neg_ff <= num[NUM_WIDTH-1] ^ den[DEN_WIDTH-1];
                  state_ff <= D_CHECK;
               end
            end
            D_CHECK: begin
               if (CW'(un_ff) >= (CW'(ud_ff) << 15)) begin
                  quot_ff  <= neg_ff ? DIST_MIN : DIST_MAX;
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end else begin
                  rem_ff   <= un_hi_in[DEN_WIDTH:0];
                  sh_ff    <= {un_ff[14:0], 16'd0};
                  q_ff     <= '0;
                  cnt_ff   <= '0;
                  state_ff <= D_RUN;
               end
            end
            default: begin
               rem_ff <= ge_in ? trial_in - {1'b0, ud_ff} : trial_in;
               sh_ff  <= {sh_ff[29:0], 1'b0};
               q_ff   <= q_in;
               cnt_ff <= cnt_ff + 5'd1;
               if (cnt_ff == 5'd30) begin
                  quot_ff  <= neg_ff ? -$signed({1'b0, q_in}) : $signed({1'b0, q_in});
                  done_ff  <= 1'b1;
                  state_ff <= D_IDLE;
               end
            end
         endcase
      end
   end
endmodule

@@ hw/rtl/robst_back.sv @@
// Back part: divides out the slab distances, narrows the interval and emits the result word.
module robst_back import robst_pkg::*; #(
   parameter int unsigned COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          pop_valid,
   output logic                          pop,
   input  logic signed [COORD_WIDTH+4:0] pop_cos,
   input  logic signed [COORD_WIDTH+4:0] pop_dst,
   input  logic [EXTENT_WIDTH-1:0]       pop_half_extent,
   input  logic                          pop_parallel,
   input  logic                          pop_last,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic [30:0]                   rsp_distance
);
   localparam int unsigned DW = COORD_WIDTH + 5;
   localparam int unsigned NW = ((DW > 32) ? DW : 32) + 1;

   typedef enum logic [1:0] {B_IDLE, B_WAIT1, B_WAIT2, B_FIN} back_state_type;

   back_state_type       state_ff;
   logic signed [DW-1:0] cos_ff, dst_ff;
   logic signed [NW-1:0] h_ff;
   logic                 par_ff, last_ff;
   logic signed [31:0]   d1_ff, near_ff, far_ff;
   logic                 missed_ff;
   logic                 rsp_valid_ff, rsp_hit_ff;
   logic [30:0]          rsp_dist_ff;
   logic                 start1, start2, div_done;
   logic signed [NW-1:0] div_num;
   logic signed [31:0]   div_quot;
   logic signed [31:0]   lo_in, hi_in, near_in, far_in;
   logic                 miss_in, commit_in;

   assign pop    = (state_ff == B_IDLE) && pop_valid;
   assign start1 = pop && !missed_ff && !pop_parallel;
   assign start2 = (state_ff == B_WAIT1) && div_done;
   assign div_num = start1 ? NW'(pop_dst) - NW'($signed({1'b0, pop_half_extent}))
                           : NW'(dst_ff) + h_ff;

   robst_div #(.NUM_WIDTH(NW), .DEN_WIDTH(DW)) u_div (
      .clock (clock),
      .reset (reset),
      .start (start1 || start2),
      .num   (div_num),
      .den   (start1 ? pop_cos : cos_ff),
      .done  (div_done),
      .quot  (div_quot)
   );

   always_comb begin
      lo_in   = (d1_ff < div_quot) ? d1_ff : div_quot;
      hi_in   = (d1_ff < div_quot) ? div_quot : d1_ff;
      near_in = near_ff;
      far_in  = far_ff;
      miss_in = missed_ff;
      if (!missed_ff) begin
         if (par_ff) begin
            if ((NW'(dst_ff) < -h_ff) || (NW'(dst_ff) > h_ff)) begin
               miss_in = 1'b1;
            end
         end else if (hi_in < 0) begin
            miss_in = 1'b1;
         end else begin
            if (lo_in < 0) begin
               lo_in = '0;
            end
            if (lo_in > near_in) begin
               near_in = lo_in;
            end
            if (hi_in < far_in) begin
               far_in = hi_in;
            end
            if (near_in > far_in) begin
               miss_in = 1'b1;
            end
         end
      end
   end

   assign commit_in    = (state_ff == B_FIN) && (!last_ff || !rsp_valid_ff || rsp_ready);
   assign rsp_valid    = rsp_valid_ff;
   assign rsp_hit      = rsp_hit_ff;
   assign rsp_distance = rsp_dist_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         near_ff      <= '0;
         far_ff       <= DIST_MAX;
         missed_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            B_IDLE: begin
               if (pop) begin
                  cos_ff  <= pop_cos;
                  dst_ff  <= pop_dst;
                  h_ff    <= NW'($signed({1'b0, pop_half_extent}));
                  par_ff  <= pop_parallel;
                  last_ff <= pop_last;
                  state_ff <= start1 ? B_WAIT1 : B_FIN;
               end
            end
            B_WAIT1: begin
               if (div_done) begin
                  d1_ff    <= div_quot;
                  state_ff <= B_WAIT2;
               end
            end
            B_WAIT2: begin
               if (div_done) begin
                  state_ff <= B_FIN;
               end
            end
            default: begin
               if (commit_in) begin
                  state_ff <= B_IDLE;
                  if (last_ff) begin
                     rsp_valid_ff <= 1'b1;
                     rsp_hit_ff   <= !miss_in;
                     rsp_dist_ff  <= miss_in ? '0 : near_in[30:0];
                     near_ff      <= '0;
                     far_ff       <= DIST_MAX;
                     missed_ff    <= 1'b0;
                  end else begin
                     near_ff   <= near_in;
                     far_ff    <= far_in;
                     missed_ff <= miss_in;
                  end
               end
            end
         endcase
      end
   end
endmodule

@@ hw/rtl/ray_oriented_box_slab_test_core.sv @@
// Top level of the ray versus oriented box slab test core.
// The user must write the ray origin and direction through the csr_ port only while
// the core is idle; the block does not enforce it. Each req_ word is one slab of an
// oriented box; the word with req_last_slab set closes the box and yields one rsp_
// word with the hit flag and the near distance (Q15.16); other slabs yield no word.
// The front part uses its single multiplier to form the nine coordinate by axis products
// one per cycle, then the word enters a two-entry queue; the front part takes no new
// slab until its word has entered the queue. The back part divides nothing for a
// parallel slab or a slab after a miss; for any other slab the serial divider yields
// one quotient bit per cycle for the two plane distances of the slab in turn. The back
// part takes no new word from the queue until it is through with the last one.
// Reset clears the registers, the queue and the running interval.
// While the receiver holds rsp_ready low, the result stays in the output register,
// the back part stops at the next closing slab and the queue then fills and
// holds req_ready low.
`include "ray_oriented_box_slab_test_core_assert.svh"
module ray_oriented_box_slab_test_core import robst_pkg::*; #(
   parameter int unsigned COORD_WIDTH = 32
) (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_write_en,
   input  logic [CSR_INDEX_WIDTH-1:0]    csr_index,
   input  logic [COORD_WIDTH-1:0]        csr_wdata,
   input  logic                          req_valid,
   output logic                          req_ready,
   input  logic signed [AXIS_WIDTH-1:0]  req_axis_x,
   input  logic signed [AXIS_WIDTH-1:0]  req_axis_y,
   input  logic signed [AXIS_WIDTH-1:0]  req_axis_z,
   input  logic [EXTENT_WIDTH-1:0]       req_half_extent,
   input  logic signed [COORD_WIDTH-1:0] req_center_x,
   input  logic signed [COORD_WIDTH-1:0] req_center_y,
   input  logic signed [COORD_WIDTH-1:0] req_center_z,
   input  logic                          req_last_slab,
   output logic                          rsp_valid,
   input  logic                          rsp_ready,
   output logic                          rsp_hit,
   output logic [30:0]                   rsp_distance
);
   localparam int unsigned DW = COORD_WIDTH + 5;
   localparam int unsigned QW = 2 * DW + EXTENT_WIDTH + 2;

   logic signed [COORD_WIDTH-1:0] origin_x_ff, origin_y_ff, origin_z_ff;
   logic signed [COORD_WIDTH-1:0] dir_x_ff, dir_y_ff, dir_z_ff;
   logic                  push_valid, q_full, q_not_empty, q_pop;
   logic signed [DW-1:0]  push_cos, push_dst;
   logic [EXTENT_WIDTH-1:0] push_h;
   logic                  push_par, push_last;
   logic [QW-1:0]         q_out;

   always_ff @(posedge clock) begin
      if (reset) begin
         origin_x_ff <= '0;
         origin_y_ff <= '0;
         origin_z_ff <= '0;
         dir_x_ff    <= '0;
         dir_y_ff    <= '0;
         dir_z_ff    <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            CSR_ORIGIN_X: origin_x_ff <= csr_wdata;
            CSR_ORIGIN_Y: origin_y_ff <= csr_wdata;
            CSR_ORIGIN_Z: origin_z_ff <= csr_wdata;
            CSR_DIR_X:    dir_x_ff    <= csr_wdata;
            CSR_DIR_Y:    dir_y_ff    <= csr_wdata;
            CSR_DIR_Z:    dir_z_ff    <= csr_wdata;
            default: ;
         endcase
      end
   end

   robst_front #(.COORD_WIDTH(COORD_WIDTH)) u_front (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_axis_x       (req_axis_x),
      .req_axis_y       (req_axis_y),
      .req_axis_z       (req_axis_z),
      .req_half_extent  (req_half_extent),
      .req_center_x     (req_center_x),
      .req_center_y     (req_center_y),
      .req_center_z     (req_center_z),
      .req_last_slab    (req_last_slab),
      .origin_x         (origin_x_ff),
      .origin_y         (origin_y_ff),
      .origin_z         (origin_z_ff),
      .dir_x            (dir_x_ff),
      .dir_y            (dir_y_ff),
      .dir_z            (dir_z_ff),
      .push_valid       (push_valid),
      .push_ready       (!q_full),
      .push_cos         (push_cos),
      .push_dst         (push_dst),
      .push_half_extent (push_h),
      .push_parallel    (push_par),
      .push_last        (push_last)
   );

   robst_fifo #(.WIDTH(QW)) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (push_valid),
      .push_data ({push_cos, push_dst, push_h, push_par, push_last}),
      .full      (q_full),
      .pop       (q_pop),
      .not_empty (q_not_empty),
      .pop_data  (q_out)
   );

   robst_back #(.COORD_WIDTH(COORD_WIDTH)) u_back (
      .clock           (clock),
      .reset           (reset),
      .pop_valid       (q_not_empty),
      .pop             (q_pop),
      .pop_cos         (q_out[QW-1 -: DW]),
      .pop_dst         (q_out[QW-DW-1 -: DW]),
      .pop_half_extent (q_out[EXTENT_WIDTH+1:2]),
      .pop_parallel    (q_out[1]),
      .pop_last        (q_out[0]),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_hit         (rsp_hit),
      .rsp_distance    (rsp_distance)
   );

   `ROBST_ASSERT_NEXT(a_front_busy_after_accept, req_valid && req_ready, !req_ready)
   `ROBST_ASSERT_IMPLY(a_miss_has_zero_distance, rsp_valid && !rsp_hit, rsp_distance == '0)
   `ROBST_ASSERT_IMPLY(a_pop_only_when_filled, q_pop, q_not_empty)
endmodule
